/* rtl/cim_pkg.sv */
// Shared constants, register codes and sequencer states for the control input mapper.
// Used by the channel interfaces, the divider and the top level; depends on nothing.
package cim_pkg;

  // Default widths of the sample and result fields.
  localparam int DEFAULT_SAMPLE_BITS = 16;
  localparam int DEFAULT_VALUE_BITS  = 32;

  // Configuration port.
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 32;
  localparam int NOISE_BITS     = 16;
  localparam int STEP_BITS      = 31;
  localparam int RANGE_BITS     = 32;

  localparam logic [CFG_INDEX_BITS-1:0] REG_MODE        = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CURVE       = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_RANGE_LOW   = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_RANGE_HIGH  = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SNAP_STEP   = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_NOISE_LEVEL = 3'd5;

  // Operating modes and slider curves.
  localparam logic [1:0] MODE_SLIDER   = 2'd0;
  localparam logic [1:0] MODE_BUTTON   = 2'd1;
  localparam logic [1:0] MODE_CHECKBOX = 2'd2;
  localparam logic [1:0] CURVE_LINEAR  = 2'd0;
  localparam logic [1:0] CURVE_LOG     = 2'd1;
  localparam logic [1:0] CURVE_EXP     = 2'd2;

  // Reset values of the registers that do not reset to zero.
  localparam logic signed [RANGE_BITS-1:0] RANGE_HIGH_RESET = 32'sd65536;
  localparam logic [NOISE_BITS-1:0]        NOISE_RESET      = 16'd3277;

  // Fixed point: working values are Q2.30, results are Q16.16.
  localparam int Q_BITS = 30;

  // Shared multiplier operand and product widths.
  localparam int MUL_A_BITS = 33;
  localparam int MUL_B_BITS = 32;
  localparam int PROD_BITS  = MUL_A_BITS + MUL_B_BITS;
  localparam int SUM_BITS   = PROD_BITS + 1;
  localparam int RND_BITS   = SUM_BITS - Q_BITS;
  localparam logic [SUM_BITS-1:0] RND_HALF = SUM_BITS'(1) << (Q_BITS - 1);

  // Curve constants in Q30.
  localparam logic [MUL_B_BITS-1:0] E_M1_Q30    = 32'd1844991064;
  localparam logic [MUL_B_BITS-1:0] C_0333_Q30  = 32'd357556027;
  localparam logic [MUL_B_BITS-1:0] C_01667_Q30 = 32'd178992762;
  localparam logic [Q_BITS-1:0]     E_HALF_Q30  = 30'd922495532;

  // Reciprocal of e - 1 for the exp divide: floor(2^62 / E_M1_Q30).
  localparam logic [MUL_B_BITS-1:0] E_RECIP_Q62 = 32'd2499570923;

  // Slider value before saturation and the snapping numerator.
  localparam int Y_BITS    = 35;
  localparam int SNUM_BITS = Y_BITS + 1;
  localparam logic signed [Y_BITS-1:0] ONE_Q16 = 35'sd65536;

  // Restoring divider used for snapping.
  localparam int DIV_NUM_BITS = 61;
  localparam int DIV_DEN_BITS = 32;
  localparam int DIV_CNT_BITS = $clog2(DIV_NUM_BITS + 1);

  // Sequencer states.
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_MUL_A,
    ST_RND_A,
    ST_MUL_B,
    ST_RND_B,
    ST_MUL_C,
    ST_RND_C,
    ST_MUL_D,
    ST_RND_D,
    ST_SHAPE,
    ST_EXP_MUL,
    ST_EXP_EST,
    ST_EXP_BACK,
    ST_EXP_FIX,
    ST_SCALE_MUL,
    ST_SCALE_RND,
    ST_SCALE,
    ST_SNAP_GO,
    ST_SNAP_WAIT,
    ST_DONE
  } cim_state_t;

endpackage

/* rtl/cim_sample_if.sv */
// Input channel carrying one knob sample per beat.
// Depends on cim_pkg for the default sample width.
interface cim_sample_if #(
  parameter int SAMPLE_BITS = cim_pkg::DEFAULT_SAMPLE_BITS
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

/* rtl/cim_value_if.sv */
// Output channel carrying one mapped control value per beat.
// Depends on cim_pkg for the default value width.
interface cim_value_if #(
  parameter int VALUE_BITS = cim_pkg::DEFAULT_VALUE_BITS
);
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] control_value;

  modport source (output valid, output control_value, input ready);
  modport sink (input valid, input control_value, output ready);
endinterface

/* rtl/control_input_mapper_top.sv */
// Control input mapper: knob sample in, saturated Q16.16 control value out.
// Button and checkbox items go straight to the result; slider items pass through the
// curve steps (none for linear) and the scaling, and through the restoring divider when
// snapping is on. The 33x32 multiplier is shared by all steps; one item is in flight, and
// the next is taken once its result is registered. Reset is synchronous, active high: it
// restores the register defaults and clears the last sample and the checkbox toggle.
module control_input_mapper_top #(
  parameter int SAMPLE_BITS = cim_pkg::DEFAULT_SAMPLE_BITS,
  parameter int VALUE_BITS  = cim_pkg::DEFAULT_VALUE_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [cim_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [cim_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  cim_sample_if.sink                         sample_ch,
  cim_value_if.source                        result_ch
);
  import cim_pkg::*;

  localparam int SAT_BITS = (VALUE_BITS > Y_BITS) ? VALUE_BITS : Y_BITS;
  localparam logic signed [SAT_BITS-1:0] SAT_HI =
    {{(SAT_BITS - VALUE_BITS + 1){1'b0}}, {(VALUE_BITS - 1){1'b1}}};
  localparam logic signed [SAT_BITS-1:0] SAT_LO = ~SAT_HI;

  // Configuration registers.
  logic [1:0]                    mode;
  logic [1:0]                    curve;
  logic signed [RANGE_BITS-1:0]  range_low;
  logic signed [RANGE_BITS-1:0]  range_high;
  logic [STEP_BITS-1:0]          snap_step;
  logic [NOISE_BITS-1:0]         noise_level;

  // Sequencer and item state.
  cim_state_t                    state;
  cim_state_t                    state_next;
  logic [SAMPLE_BITS-1:0]        last_sample;
  logic [SAMPLE_BITS-1:0]        samp;
  logic                          toggle_flag;
  logic                          toggle_next;

  // Datapath registers.
  logic [Q_BITS-1:0]             t;
  logic [30:0]                   r1;
  logic [31:0]                   r2;
  logic [32:0]                   r3;
  logic [30:0]                   v;
  logic [31:0]                   dm;
  logic                          dneg;
  logic [32:0]                   pm;
  logic signed [Y_BITS-1:0]      y;
  logic [SNUM_BITS-1:0]          snum;
  logic [PROD_BITS-1:0]          prod;
  logic                          out_valid;
  logic signed [VALUE_BITS-1:0]  out_value;

  // Combinational signals.
  logic                          is_log;
  logic                          is_exp;
  logic                          out_free;
  logic                          load_out;
  logic [MUL_A_BITS-1:0]         mul_a;
  logic [MUL_B_BITS-1:0]         mul_b;
  logic [SUM_BITS-1:0]           prod_sum;
  logic [RND_BITS-1:0]           prod_rnd;
  logic [Q_BITS-1:0]             t_in;
  logic [Q_BITS-1:0]             p_q;
  logic [Q_BITS-1:0]             n_q;
  logic [Q_BITS-1:0]             rise;
  logic                          above;
  logic [RANGE_BITS:0]           diff_hl;
  logic [RANGE_BITS:0]           diff_lh;
  logic [Y_BITS-1:0]             shape_diff;
  logic [30:0]                   exp_num;
  logic [33:0]                   exp_rem;
  logic [1:0]                    exp_adj;
  logic signed [Y_BITS-1:0]      lo_ext;
  logic signed [Y_BITS-1:0]      pm_ext;
  logic [SNUM_BITS-1:0]          st_ext;
  logic [SNUM_BITS-1:0]          y_x2;
  logic [SNUM_BITS-1:0]          snum_calc;
  logic [SNUM_BITS-1:0]          snap_pos;
  logic [SNUM_BITS-1:0]          snap_neg;
  logic signed [SAT_BITS-1:0]    y_ext;
  logic signed [SAT_BITS-1:0]    y_sat;
  logic                          div_start;
  logic [DIV_NUM_BITS-1:0]       div_num;
  logic [DIV_DEN_BITS-1:0]       div_den;
  logic                          div_done;
  logic [DIV_NUM_BITS-1:0]       div_quo;
  logic [DIV_DEN_BITS-1:0]       div_rem;

  // Divider for snapping.
  cim_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_SLIDER;
      curve       <= CURVE_LINEAR;
      range_low   <= '0;
      range_high  <= RANGE_HIGH_RESET;
      snap_step   <= '0;
      noise_level <= NOISE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODE:        mode        <= cfg_data[1:0];
        REG_CURVE:       curve       <= cfg_data[1:0];
        REG_RANGE_LOW:   range_low   <= signed'(cfg_data[RANGE_BITS-1:0]);
        REG_RANGE_HIGH:  range_high  <= signed'(cfg_data[RANGE_BITS-1:0]);
        REG_SNAP_STEP:   snap_step   <= cfg_data[STEP_BITS-1:0];
        REG_NOISE_LEVEL: noise_level <= cfg_data[NOISE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Thresholds for button and checkbox, all aligned to Q30.
  always_comb begin
    is_log      = (curve == CURVE_LOG);
    is_exp      = (curve == CURVE_EXP);
    t_in        = Q_BITS'(sample_ch.sample) << (Q_BITS - SAMPLE_BITS);
    p_q         = Q_BITS'(last_sample) << (Q_BITS - SAMPLE_BITS);
    n_q         = Q_BITS'(noise_level) << (Q_BITS - NOISE_BITS);
    rise        = t - p_q;
    above       = (t > n_q);
    toggle_next = toggle_flag ^ ((mode == MODE_CHECKBOX) && above && (t > p_q) && (rise > n_q));
  end

  // Rounded Q30 product and the small adders around the shared units.
  always_comb begin
    prod_sum   = SUM_BITS'(prod) + RND_HALF;
    prod_rnd   = prod_sum[SUM_BITS-1:Q_BITS];
    diff_hl    = (RANGE_BITS+1)'(range_high) - (RANGE_BITS+1)'(range_low);
    diff_lh    = (RANGE_BITS+1)'(range_low) - (RANGE_BITS+1)'(range_high);
    shape_diff = Y_BITS'(r1) + Y_BITS'(r3) - Y_BITS'(r2 >> 1) - Y_BITS'(r2[0]);
    exp_num    = 31'(t) + 31'(r1 >> 1) + 31'(r1[0]) + r3[30:0];
    // Remainder of the exp divide left by the reciprocal estimate; it is below 3(e-1).
    exp_rem    = {v[3:0], E_HALF_Q30} - prod[33:0];
    if (exp_rem >= {1'b0, E_M1_Q30, 1'b0}) begin
      exp_adj = 2'd2;
    end else if (exp_rem >= 34'(E_M1_Q30)) begin
      exp_adj = 2'd1;
    end else begin
      exp_adj = 2'd0;
    end
    lo_ext     = Y_BITS'(range_low);
    pm_ext     = signed'(Y_BITS'(pm));
    st_ext     = SNUM_BITS'(snap_step);
    y_x2       = {y, 1'b0};
    snum_calc  = y[Y_BITS-1] ? (st_ext - y_x2) : (st_ext + y_x2);
    snap_pos   = snum - SNUM_BITS'(div_rem);
    snap_neg   = SNUM_BITS'(div_rem) - snum;
    y_ext      = SAT_BITS'(y);
    if (y_ext > SAT_HI) begin
      y_sat = SAT_HI;
    end else if (y_ext < SAT_LO) begin
      y_sat = SAT_LO;
    end else begin
      y_sat = y_ext;
    end
  end

  assign out_free = !out_valid || result_ch.ready;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (sample_ch.valid) state_next = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        if (mode != MODE_SLIDER) begin
          state_next = ST_DONE;
        end else if (is_log || is_exp) begin
          state_next = ST_MUL_A;
        end else begin
          state_next = ST_SCALE_MUL;
        end
      end
      ST_MUL_A:     state_next = ST_RND_A;
      ST_RND_A:     state_next = ST_MUL_B;
      ST_MUL_B:     state_next = ST_RND_B;
      ST_RND_B:     state_next = ST_MUL_C;
      ST_MUL_C:     state_next = ST_RND_C;
      ST_RND_C:     state_next = is_log ? ST_MUL_D : ST_SHAPE;
      ST_MUL_D:     state_next = ST_RND_D;
      ST_RND_D:     state_next = ST_SHAPE;
      ST_SHAPE:     state_next = is_log ? ST_SCALE_MUL : ST_EXP_MUL;
      ST_EXP_MUL:   state_next = ST_EXP_EST;
      ST_EXP_EST:   state_next = ST_EXP_BACK;
      ST_EXP_BACK:  state_next = ST_EXP_FIX;
      ST_EXP_FIX:   state_next = ST_SCALE_MUL;
      ST_SCALE_MUL: state_next = ST_SCALE_RND;
      ST_SCALE_RND: state_next = ST_SCALE;
      ST_SCALE:     state_next = (snap_step != '0) ? ST_SNAP_GO : ST_DONE;
      ST_SNAP_GO:   state_next = ST_SNAP_WAIT;
      ST_SNAP_WAIT: begin
        if (div_done) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default:      state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs: handshake, multiplier operands and divider requests.
  always_comb begin
    sample_ch.ready = (state == ST_IDLE);
    load_out        = (state == ST_DONE) && out_free;
    mul_a           = '0;
    mul_b           = '0;
    div_start       = 1'b0;
    div_num         = '0;
    div_den         = '0;
    case (state)
      ST_MUL_A: begin
        mul_a = MUL_A_BITS'(t);
        mul_b = is_log ? E_M1_Q30 : MUL_B_BITS'(t);
      end
      ST_MUL_B: begin
        mul_a = MUL_A_BITS'(r1);
        mul_b = is_log ? MUL_B_BITS'(r1) : MUL_B_BITS'(t);
      end
      ST_MUL_C: begin
        mul_a = MUL_A_BITS'(r2);
        mul_b = is_log ? MUL_B_BITS'(r1) : C_01667_Q30;
      end
      ST_MUL_D: begin
        mul_a = r3;
        mul_b = C_0333_Q30;
      end
      ST_EXP_MUL: begin
        mul_a = MUL_A_BITS'(v);
        mul_b = E_RECIP_Q62;
      end
      ST_EXP_BACK: begin
        mul_a = MUL_A_BITS'(r2);
        mul_b = E_M1_Q30;
      end
      ST_SCALE_MUL: begin
        mul_a = MUL_A_BITS'(v);
        mul_b = dm;
      end
      ST_SNAP_GO: begin
        div_start = 1'b1;
        div_num   = DIV_NUM_BITS'(snum_calc);
        div_den   = {snap_step, 1'b0};
      end
      default: ;
    endcase
  end

  // Control state: sequencer, stored sample, toggle and result valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      last_sample <= '0;
      toggle_flag <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_DISPATCH) begin
        last_sample <= samp;
        toggle_flag <= toggle_next;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (result_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers, written by the step that produces them.
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    case (state)
      ST_IDLE: begin
        t    <= t_in;
        samp <= sample_ch.sample;
      end
      ST_DISPATCH: begin
        v    <= 31'(t);
        dneg <= diff_hl[RANGE_BITS];
        dm   <= diff_hl[RANGE_BITS] ? diff_lh[RANGE_BITS-1:0] : diff_hl[RANGE_BITS-1:0];
        if (mode == MODE_BUTTON) begin
          y <= above ? ONE_Q16 : '0;
        end else if (mode == MODE_CHECKBOX) begin
          y <= toggle_next ? ONE_Q16 : '0;
        end else begin
          y <= '0;
        end
      end
      ST_RND_A: r1 <= prod_rnd[30:0];
      ST_RND_B: r2 <= prod_rnd[31:0];
      ST_RND_C: r3 <= prod_rnd[32:0];
      ST_RND_D: r3 <= prod_rnd[32:0];
      ST_SHAPE: begin
        // Log is clamped at zero; exp keeps its numerator here until the divide.
        if (is_log) begin
          v <= (!shape_diff[Y_BITS-1] && (shape_diff != '0)) ? shape_diff[30:0] : '0;
        end else begin
          v <= exp_num;
        end
      end
      // The reciprocal product gives a quotient estimate at most two short.
      ST_EXP_EST: r2 <= prod[63:32];
      ST_EXP_FIX: v <= 31'(r2) + 31'(exp_adj);
      ST_SCALE_RND: pm <= prod_rnd[32:0];
      ST_SCALE: y <= dneg ? (lo_ext - pm_ext) : (lo_ext + pm_ext);
      ST_SNAP_GO: snum <= snum_calc;
      ST_SNAP_WAIT: begin
        // The quotient times the step is half of the numerator less the remainder.
        if (div_done) begin
          y <= y[Y_BITS-1] ? signed'(snap_neg[SNUM_BITS-1:1])
                           : signed'(snap_pos[SNUM_BITS-1:1]);
        end
      end
      default: ;
    endcase
    if (load_out) out_value <= VALUE_BITS'(y_sat);
  end

  assign result_ch.valid         = out_valid;
  assign result_ch.control_value = out_value;

  // The toggle only moves when a checkbox item is dispatched.
  assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && (toggle_flag != $past(toggle_flag)))
      |-> ($past(state) == ST_DISPATCH && $past(mode) == MODE_CHECKBOX))
    else $error("toggle changed outside a checkbox dispatch");

  // Divider results only arrive while the sequencer waits for them.
  assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_SNAP_WAIT))
    else $error("divider finished while not awaited");

  // The snap quotient never exceeds the width of the slider value.
  assert property (@(posedge clk) disable iff (rst)
    div_done |-> (div_quo[DIV_NUM_BITS-1:SNUM_BITS-1] == '0))
    else $error("snap quotient wider than the slider value");

  // Snapping is only started with a nonzero step.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_SNAP_GO) |-> (snap_step != '0))
    else $error("snap divide started with a zero step");

  // A new result beat appears only from the final step.
  assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $rose(out_valid)) |-> ($past(state) == ST_DONE))
    else $error("result valid raised outside the final step");
endmodule

/* rtl/cim_div.sv */
// Restoring divider, one quotient bit per cycle, used to snap slider values to the step.
// Depends on cim_pkg for its widths.
module cim_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [cim_pkg::DIV_NUM_BITS-1:0]  num,
  input  logic [cim_pkg::DIV_DEN_BITS-1:0]  den,
  output logic                              done,
  output logic [cim_pkg::DIV_NUM_BITS-1:0]  quo,
  output logic [cim_pkg::DIV_DEN_BITS-1:0]  rem
);
  import cim_pkg::*;

  logic                    busy;
  logic [DIV_CNT_BITS-1:0] cnt;
  logic [DIV_DEN_BITS-1:0] den_r;
  logic [DIV_DEN_BITS:0]   trial;
  logic [DIV_DEN_BITS:0]   trial_sub;
  logic                    fits;

  // Bring down the next numerator bit and try the divisor.
  always_comb begin
    trial     = {rem, quo[DIV_NUM_BITS-1]};
    trial_sub = trial - {1'b0, den_r};
    fits      = (trial >= {1'b0, den_r});
  end

  // Control: count the steps and flag the last one.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_BITS'(DIV_NUM_BITS);
      end else if (busy) begin
        cnt <= cnt - DIV_CNT_BITS'(1);
        if (cnt == DIV_CNT_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: the numerator shifts out as the quotient shifts in.
  always_ff @(posedge clk) begin
    if (start) begin
      quo   <= num;
      rem   <= '0;
      den_r <= den;
    end else if (busy) begin
      quo <= {quo[DIV_NUM_BITS-2:0], fits};
      rem <= fits ? trial_sub[DIV_DEN_BITS-1:0] : trial[DIV_DEN_BITS-1:0];
    end
  end
endmodule
